FILE: src/assert_macros.svh
// Shared assertion macros for the allocator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

FILE: src/bth_pkg.sv
`default_nettype none

package bth_pkg;

   localparam int MAX_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 4096;   // power of two

   localparam int ADDR_W      = 32;
   localparam int SPAN_CFG_W  = 11;
   localparam int IDX_W       = $clog2(MAX_BLOCKS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int BLK_W       = ADDR_W - BLOCK_SHIFT;
   localparam int NEED_W      = BLK_W + 1;

   localparam int REQ_TDATA_W = 2 * ADDR_W;
   localparam int RSP_TDATA_W = ((ADDR_W + 1 + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 1;

   localparam logic [1:0] MARK_FREE  = 2'b00;
   localparam logic [1:0] MARK_TAKEN = 2'b01;
   localparam logic [1:0] MARK_CHAIN = 2'b10;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_HEAP_BASE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_MARK,
      ST_RELEASE,
      ST_RESPOND
   } bth_state_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic prep;
      logic scan_step;
      logic mark_step;
      logic rel_step;
      logic set_fail;
      logic load_rsp;
   } bth_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_release;
      logic alloc_bad;
      logic rel_skip;
      logic scan_hit;
      logic scan_end;
      logic mark_last;
      logic rel_end;
      logic rsp_free;
   } bth_status_type;

endpackage

`default_nettype wire

FILE: src/bth_ctrl.sv
`default_nettype none

module bth_ctrl import bth_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire bth_status_type sts,
   output bth_cmd_type         cmd
);

   bth_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.is_release) begin
               state_in = sts.rel_skip ? ST_RESPOND : ST_RELEASE;
            end else begin
               state_in = sts.alloc_bad ? ST_RESPOND : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_hit) state_in = ST_MARK;
            else if (sts.scan_end) state_in = ST_RESPOND;
         end
         ST_MARK: begin
            if (sts.mark_last) state_in = ST_RESPOND;
         end
         ST_RELEASE: begin
            if (sts.rel_end) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECIDE: begin
            cmd.prep     = 1'b1;
            cmd.set_fail = !sts.is_release && sts.alloc_bad;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            // run not found before the end of the span
            cmd.set_fail  = sts.scan_end && !sts.scan_hit;
         end
         ST_MARK:    cmd.mark_step = 1'b1;
         ST_RELEASE: cmd.rel_step  = 1'b1;
         ST_RESPOND: cmd.load_rsp  = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/bth_datapath.sv
`default_nettype none

module bth_datapath import bth_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bth_cmd_type            cmd,
   output bth_status_type              sts,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ADDR_W-1:0]      csr_wdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic [1:0] marks_mem [MAX_BLOCKS];

   logic [ADDR_W-1:0]     base_ff;
   logic [SPAN_CFG_W-1:0] span_cfg_ff;

   logic                  func_ff, func_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [BLK_W-1:0]      blk_ff, blk_in;
   logic                  fail_ff, fail_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   logic [IDX_W-1:0]      start_ff, start_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [1:0]            rdata_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]      span;
   logic                  issue;
   logic                  scan_hit;
   logic                  span_done;
   logic [ADDR_W-1:0]     offset;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [1:0]            mem_wdata;

   // heap span saturates at the table depth
   always_comb begin
      if (32'(span_cfg_ff) > 32'(MAX_BLOCKS)) span = CNT_W'(MAX_BLOCKS);
      else span = CNT_W'(span_cfg_ff);
   end

   assign issue     = (cmd.scan_step || cmd.rel_step) && (ptr_ff < span);
   assign span_done = (ptr_ff >= span) && !rd_valid_ff;
   assign scan_hit  = cmd.scan_step && rd_valid_ff && (rdata_ff == MARK_FREE) &&
                      (32'(run_ff) + 32'd1 == 32'(need_ff));
   assign offset    = req_tdata[2*ADDR_W-1:ADDR_W] - base_ff;

   always_comb begin
      func_in       = func_ff;
      need_in       = need_ff;
      blk_in        = blk_ff;
      fail_in       = fail_ff;
      ptr_in        = ptr_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      rd_valid_in   = issue;
      rd_idx_in     = ptr_ff[IDX_W-1:0];
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (cmd.capture) begin
         func_in = req_tuser;
         // round the byte count up to whole blocks
         need_in = NEED_W'(req_tdata[ADDR_W-1:BLOCK_SHIFT]) +
                   NEED_W'(|req_tdata[BLOCK_SHIFT-1:0]);
         blk_in  = offset[ADDR_W-1:BLOCK_SHIFT];
         fail_in = 1'b0;
      end

      if (cmd.prep) begin
         ptr_in = (func_ff == FUNC_RELEASE) ? CNT_W'(blk_ff) : '0;
         run_in = '0;
      end

      if (cmd.clear_step) ptr_in = ptr_ff + CNT_W'(1);

      if (cmd.scan_step) begin
         if (issue) ptr_in = ptr_ff + CNT_W'(1);
         if (rd_valid_ff) begin
            if (rdata_ff != MARK_FREE) begin
               run_in = '0;
            end else begin
               if (run_ff == '0) start_in = rd_idx_ff;
               run_in = run_ff + CNT_W'(1);
            end
         end
         // rewind to the run start and mark it
         if (scan_hit) begin
            ptr_in = (run_ff == '0) ? CNT_W'(rd_idx_ff) : CNT_W'(start_ff);
            run_in = CNT_W'(need_ff);
         end
      end

      if (cmd.mark_step) begin
         ptr_in = ptr_ff + CNT_W'(1);
         run_in = run_ff - CNT_W'(1);
      end

      if (cmd.rel_step && issue) ptr_in = ptr_ff + CNT_W'(1);

      if (cmd.set_fail) fail_in = 1'b1;

      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fail_ff;
         if (fail_ff || func_ff == FUNC_RELEASE) rsp_addr_in = '0;
         else rsp_addr_in = base_ff + (ADDR_W'(start_ff) << BLOCK_SHIFT);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff[IDX_W-1:0];
      mem_wdata = MARK_FREE;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.mark_step) begin
         mem_we    = 1'b1;
         mem_wdata = (run_ff == CNT_W'(1)) ? MARK_TAKEN : (MARK_TAKEN | MARK_CHAIN);
      end else if (cmd.rel_step) begin
         mem_we    = rd_valid_ff;
         mem_waddr = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) marks_mem[mem_waddr] <= mem_wdata;
      if (issue) rdata_ff <= marks_mem[ptr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         span_cfg_ff  <= SPAN_CFG_W'(MAX_BLOCKS);
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_HEAP_BASE) base_ff <= csr_wdata;
         if (csr_we && csr_index == REG_BLOCKS_IN_USE) begin
            span_cfg_ff <= csr_wdata[SPAN_CFG_W-1:0];
         end
         ptr_ff       <= ptr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      need_ff       <= need_in;
      blk_ff        <= blk_in;
      fail_ff       <= fail_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      sts            = '0;
      sts.clear_last = (ptr_ff == CNT_W'(MAX_BLOCKS - 1));
      sts.is_release = (func_ff == FUNC_RELEASE);
      sts.alloc_bad  = (need_ff == '0) || (32'(need_ff) > 32'(span));
      sts.rel_skip   = (32'(blk_ff) >= 32'(span));
      sts.scan_hit   = scan_hit;
      sts.scan_end   = span_done;
      sts.mark_last  = (run_ff == CNT_W'(1));
      // stop on a block without the chain flag, or at the end of the span
      sts.rel_end    = (rd_valid_ff && ((rdata_ff & MARK_CHAIN) == MARK_FREE)) || span_done;
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - ADDR_W - 1)'(0), rsp_status_ff, rsp_addr_ff};

endmodule

`default_nettype wire

FILE: src/block_table_heap_allocator_core.sv
`default_nettype none
// Channel   Direction  Transfer when          Payload
// req_      in         req_tvalid&req_tready  tdata: request_bytes, release_address
//                                             tuser: func
// rsp_      out        rsp_tvalid&rsp_tready  tdata: granted_address, status
// csr_      in         csr_we                 csr_index selects base or block count
//
// One request at a time. Allocate: a first-fit scan that walks the table through its
// single read port, one entry a cycle, then a pass that marks the run it found.
// Release: a chain walk that frees its blocks; a rejected request skips the table.
// After reset a clearing pass writes all 1024 table entries, one a cycle, with
// req_tready low. A result waiting in the output register does not stop the next
// request from being accepted; only its own result waits on rsp_tready.

module block_table_heap_allocator_core import bth_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // request_bytes, release_address
   input  wire logic                   req_tuser,   // func
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // granted_address, status, zero pad
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ADDR_W-1:0]      csr_wdata
);

   bth_cmd_type    cmd;
   bth_status_type sts;

   bth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bth_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: src/bth_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bth_checker import bth_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // hold a stalled result
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // reset starts the clearing pass with both channels quiet
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !req_tready && !rsp_tvalid)

   // one request in flight at a time
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // a failed request reports address zero
   `ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_tvalid && rsp_tdata[ADDR_W], rsp_tdata[ADDR_W-1:0] == '0)

endmodule

bind block_table_heap_allocator_core bth_checker u_bth_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
   import bth_pkg::*;

   localparam int LIMIT_CYCLES = 6_000_000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 2200;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] bytes;
      logic [ADDR_W-1:0] rel_addr;
   } heap_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              status;
   } heap_grant_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // request_bytes, release_address
   logic                   req_tuser = 1'b0; // func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // granted_address, status, zero pad
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [ADDR_W-1:0]      csr_wdata = '0;

   // heap shadow
   logic [1:0]            marks_model [MAX_BLOCKS];
   logic [ADDR_W-1:0]     base_model;
   logic [SPAN_CFG_W-1:0] span_cfg_model;

   heap_req_type      heap_requests[$];
   heap_grant_type    expected_grants[$];
   logic [ADDR_W-1:0] granted_chains[$];
   heap_req_type      offered_req;

   int          tx_gap = 0;
   int          rx_stall = 0;
   logic        tx_idle = 1'b1;
   logic        rx_idle = 1'b1;
   logic        backpressure_kick = 1'b0;
   int          backpressure_left = 0;
   int unsigned cycle_count = 0;
   int          mismatch_count = 0;

   block_table_heap_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int heap_span();
      return (span_cfg_model > MAX_BLOCKS) ? MAX_BLOCKS : int'(span_cfg_model);
   endfunction

   // First-fit allocate or chain release on the shadow table.
   function automatic heap_grant_type apply_heap_request(heap_req_type r);
      heap_grant_type    res;
      int                span;
      int                run;
      int                start;
      int                i;
      logic [63:0]       need;
      logic [ADDR_W-1:0] offs;
      logic [1:0]        old;
      res.addr   = '0;
      res.status = 1'b0;
      span       = heap_span();
      if (r.func == FUNC_ALLOC) begin
         need  = ({32'd0, r.bytes} + BLOCK_BYTES - 1) / BLOCK_BYTES;
         run   = 0;
         start = 0;
         if (need != 0 && need <= span) begin
            for (i = 0; i < span && run != need; i++) begin
               if (marks_model[i] != MARK_FREE) begin
                  run = 0;
               end else begin
                  if (run == 0) start = i;
                  run++;
               end
            end
         end
         if (need != 0 && run == need) begin
            for (i = 0; i < run; i++)
               marks_model[start + i] = (i + 1 < run) ? (MARK_TAKEN | MARK_CHAIN) : MARK_TAKEN;
            res.addr = base_model + start * BLOCK_BYTES;
            granted_chains.push_back(res.addr);
         end else begin
            res.status = 1'b1;
         end
      end else begin
         offs = r.rel_addr - base_model;
         i    = offs / BLOCK_BYTES;
         // clear up to the first block without a chain bit, never past the span
         while (i < span) begin
            old            = marks_model[i];
            marks_model[i] = MARK_FREE;
            if ((old & MARK_CHAIN) == MARK_FREE) break;
            i++;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic push_req(input logic func, input logic [ADDR_W-1:0] bytes,
                           input logic [ADDR_W-1:0] rel_addr);
      heap_req_type r;
      r.func     = func;
      r.bytes    = bytes;
      r.rel_addr = rel_addr;
      heap_requests.push_back(r);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_HEAP_BASE)
         base_model = value;
      else
         span_cfg_model = value[SPAN_CFG_W-1:0];
   endtask

   task automatic drain();
      while (heap_requests.size() != 0 || req_tvalid || expected_grants.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Mostly allocate/release pairs on live chains, some noise.
   task automatic run_random(input int count);
      int                n;
      int                span;
      int                need;
      int                k;
      logic [ADDR_W-1:0] a;
      span = heap_span();
      for (n = 0; n < count; n++) begin
         while (heap_requests.size() >= 2) @(negedge clock);
         k = $urandom_range(0, 99);
         if (k < 55) begin
            if (span == 0)
               need = $urandom_range(1, 4);
            else if ($urandom_range(0, 7) == 0)
               need = $urandom_range(1, span);
            else
               need = $urandom_range(1, (span < 6) ? span : 6);
            push_req(FUNC_ALLOC, (need - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES),
                     $urandom());
         end else if (k < 85 && granted_chains.size() != 0) begin
            k = $urandom_range(0, granted_chains.size() - 1);
            a = granted_chains[k];
            granted_chains.delete(k);
            // land inside the block or further down the chain now and then
            case ($urandom_range(0, 3))
               0: a = a + $urandom_range(1, BLOCK_BYTES - 1);
               1: a = a + BLOCK_BYTES * $urandom_range(1, 3);
               default: ;
            endcase
            push_req(FUNC_RELEASE, $urandom(), a);
         end else begin
            case ($urandom_range(0, 2))
               0: push_req(1'($urandom_range(0, 1)), $urandom(), $urandom());
               1: push_req(FUNC_RELEASE, $urandom(),
                           base_model + $urandom_range(0, span + 2) * BLOCK_BYTES
                           + $urandom_range(0, BLOCK_BYTES - 1));
               default: push_req(FUNC_ALLOC, $urandom_range(0, 1) ? 32'd0 : $urandom(),
                                 $urandom());
            endcase
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      logic stuck;
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap = 0;
      end else begin
         stuck = req_tvalid && !req_tready;
         if (req_tvalid && req_tready)
            expected_grants.push_back(apply_heap_request(offered_req));
         if (!stuck) begin
            if (tx_gap != 0) begin
               tx_gap = tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (heap_requests.size() != 0) begin
               offered_req = heap_requests.pop_front();
               req_tdata  <= {offered_req.rel_addr, offered_req.bytes};
               req_tuser  <= offered_req.func;
               req_tvalid <= 1'b1;
               tx_gap = tx_idle ? $urandom_range(0, 7) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      heap_grant_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = expected_grants.pop_front();
               if (rsp_tdata[ADDR_W-1:0] !== want.addr || rsp_tdata[ADDR_W] !== want.status)
                  report_mismatch($sformatf("got addr %h status %b, want addr %h status %b",
                                            rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W],
                                            want.addr, want.status));
            end
            rx_stall = rx_idle ? $urandom_range(0, 7) : 0;
         end else if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
         end
         rsp_tready <= (rx_stall == 0) && (backpressure_left == 0);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset)
         backpressure_left <= 0;
      else if (backpressure_kick)
         backpressure_left <= HOLD_CYCLES;
      else if (backpressure_left != 0)
         backpressure_left <= backpressure_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] b;
      foreach (marks_model[i]) marks_model[i] = MARK_FREE;
      base_model     = '0;
      span_cfg_model = SPAN_CFG_W'(MAX_BLOCKS);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // hold off until the table clearing pass is done
      @(negedge clock);
      while (!req_tready) @(negedge clock);

      b = 32'h8000_0000;
      write_csr(REG_HEAP_BASE, b);
      write_csr(REG_BLOCKS_IN_USE, MAX_BLOCKS);
      push_req(FUNC_ALLOC, 32'd0, 32'hFFFF_FFFF);               // zero size
      push_req(FUNC_ALLOC, 32'd1, 32'd0);
      push_req(FUNC_ALLOC, BLOCK_BYTES, 32'd0);
      push_req(FUNC_ALLOC, BLOCK_BYTES + 1, 32'd0);
      push_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // far beyond the heap
      push_req(FUNC_ALLOC, 3 * BLOCK_BYTES, 32'd0);
      push_req(FUNC_RELEASE, 32'd0, b + 5 * BLOCK_BYTES);        // middle of a chain
      push_req(FUNC_RELEASE, 32'd0, b + 2 * BLOCK_BYTES + 123);  // unaligned start
      push_req(FUNC_RELEASE, 32'd0, b + 100 * BLOCK_BYTES);      // free block
      push_req(FUNC_RELEASE, 32'd0, b - BLOCK_BYTES);            // below the base
      push_req(FUNC_RELEASE, 32'd0, b + MAX_BLOCKS * BLOCK_BYTES);
      push_req(FUNC_ALLOC, 2 * BLOCK_BYTES, 32'd0);
      push_req(FUNC_ALLOC, 1020 * BLOCK_BYTES, 32'd0);           // trailing run too short
      push_req(FUNC_ALLOC, 1019 * BLOCK_BYTES, 32'd0);
      push_req(FUNC_ALLOC, 32'd1, 32'd0);                        // heap full
      push_req(FUNC_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(FUNC_RELEASE, 32'hFFFF_FFFF, 32'd0);
      drain();

      // chain running past a shrunk span
      write_csr(REG_BLOCKS_IN_USE, 16);
      push_req(FUNC_RELEASE, 32'd0, b + 5 * BLOCK_BYTES);
      push_req(FUNC_ALLOC, 11 * BLOCK_BYTES, 32'd0);
      push_req(FUNC_RELEASE, 32'd0, b + 4 * BLOCK_BYTES);
      push_req(FUNC_ALLOC, 16 * BLOCK_BYTES, 32'd0);
      drain();
      write_csr(REG_BLOCKS_IN_USE, MAX_BLOCKS);
      push_req(FUNC_RELEASE, 32'd0, b + 16 * BLOCK_BYTES);
      drain();

      write_csr(REG_HEAP_BASE, $urandom() & ~(BLOCK_BYTES - 1));
      run_random(200);
      drain();

      // small heap that wraps past the top of the address space, no idling
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      write_csr(REG_HEAP_BASE, 32'hFFFF_C000);
      write_csr(REG_BLOCKS_IN_USE, 16);
      @(posedge clock);
      backpressure_kick <= 1'b1;
      @(posedge clock);
      backpressure_kick <= 1'b0;
      run_random(100);
      drain();
      tx_idle = 1'b1;
      rx_idle = 1'b1;

      write_csr(REG_HEAP_BASE, 32'hFFFF_FFFF);
      write_csr(REG_BLOCKS_IN_USE, 1);
      run_random(40);
      drain();

      write_csr(REG_BLOCKS_IN_USE, 0);
      run_random(12);
      drain();

      write_csr(REG_HEAP_BASE, 32'd0);
      write_csr(REG_BLOCKS_IN_USE, 2047);
      run_random(100);
      drain();

      write_csr(REG_HEAP_BASE, $urandom() & ~(BLOCK_BYTES - 1));
      write_csr(REG_BLOCKS_IN_USE, $urandom_range(2, MAX_BLOCKS - 1));
      run_random(105);
      drain();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
